// ----- rtl/core/sawbc_pkg.sv -----
// Shared types, constants and geometry helper for the set-associative cache.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package sawbc_pkg;

    localparam int ADDR_BITS   = 16;
    localparam int MEM_BYTES   = 65536;
    localparam int CACHE_BYTES = 4096;
    localparam int MAX_WAYS    = 8;
    localparam int MAX_SETS_L2 = 10;
    localparam int MIN_BLK_L2  = 2;
    localparam int SLOTS       = CACHE_BYTES / 4;
    localparam int SLOT_BITS   = $clog2(SLOTS);
    localparam int LINE_BITS   = $clog2(CACHE_BYTES);
    localparam int WAY_BITS    = $clog2(MAX_WAYS);
    localparam int OFF_BITS    = 7;
    localparam int CNT_BITS    = 32;
    localparam int PCT_BITS    = 7;
    localparam int PCT_SCALE   = 100;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_WAYS  = 2'd0,
        REG_BLOCK = 2'd1,
        REG_SETS  = 2'd2
    } reg_idx_t;

    // effective geometry after clamping
    typedef struct packed {
        logic [3:0] ways;
        logic [2:0] blk;
        logic [3:0] sets;
    } geo_t;

    // one tag store entry
    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [15:0]         tag;
        logic [CNT_BITS-1:0] age;
    } meta_t;

    // controller to datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LATCH,
        CMD_SETUP,
        CMD_SCAN_RD,
        CMD_SCAN_CHK,
        CMD_DECIDE,
        CMD_WB,
        CMD_FILL,
        CMD_TCH_RD,
        CMD_TCH_WR,
        CMD_ACCESS,
        CMD_RESULT,
        CMD_LOAD_OUT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                op;
        logic [ADDR_BITS-1:0]   idx;
    } cmd_t;

    // datapath status back to the controller
    typedef struct packed {
        logic hit;
        logic victim_wb;
    } sts_t;

    // clamp the registers and shrink the set count until the cache fits
    function automatic geo_t geo_settle(logic [3:0] wc, logic [2:0] bl, logic [3:0] sc);
        geo_t        g;
        logic [3:0]  w;
        logic [2:0]  b;
        logic [3:0]  s;
        logic [20:0] need;
        w = (wc == 4'd0) ? 4'd1 : ((wc > 4'(MAX_WAYS)) ? 4'(MAX_WAYS) : wc);
        b = (bl < 3'(MIN_BLK_L2)) ? 3'(MIN_BLK_L2) : bl;
        s = (sc > 4'(MAX_SETS_L2)) ? 4'(MAX_SETS_L2) : sc;
        g.ways = w;
        g.blk  = b;
        g.sets = 4'd0;
        for (int k = 1; k <= MAX_SETS_L2; k++) begin
            need = 21'(w) << (k + int'(b));
            if (k <= int'(s) && need <= 21'(CACHE_BYTES)) begin
                g.sets = 4'(k);
            end
        end
        return g;
    endfunction

endpackage

// ----- rtl/core/set_assoc_write_back_lru_cache_unit.sv -----
// Top level: configuration registers, geometry clamping and block wiring.
// Depends on sawbc_pkg, sawbc_div, sawbc_dpath and sawbc_ctrl.
// After reset a clearing pass zeroes main memory and the tag store.
// A miss adds a block fill, and a dirty victim is written back before the fill.
// One item is in work at a time; the next is taken while a result waits for m_tready.
`timescale 1ns / 1ps

module set_assoc_write_back_lru_cache_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: op [0], address [16:1], write_data [24:17], zeros above
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // m_tdata: read_data [7:0], hit [8], miss_percent [15:9]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0]      ways_reg;
    logic [2:0]      blk_reg;
    logic [3:0]      sets_reg;
    logic            cfg_wr;
    sawbc_pkg::geo_t geo;
    sawbc_pkg::cmd_t cmd;
    sawbc_pkg::sts_t sts;
    logic            div_done;
    logic [sawbc_pkg::PCT_BITS-1:0]  pct;
    logic [sawbc_pkg::CNT_BITS-1:0]  miss_cnt;
    logic [sawbc_pkg::CNT_BITS:0]    total;
    logic [7:0]                      read_data;
    logic                            hit;
    logic [sawbc_pkg::PCT_BITS-1:0]  miss_percent;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ways_reg <= 4'd1;
            blk_reg  <= 3'd4;
            sets_reg <= 4'd6;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                sawbc_pkg::REG_WAYS:  ways_reg <= pwdata[3:0];
                sawbc_pkg::REG_BLOCK: blk_reg  <= pwdata[2:0];
                sawbc_pkg::REG_SETS:  sets_reg <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[3:2])
            sawbc_pkg::REG_WAYS:  prdata = 32'(ways_reg);
            sawbc_pkg::REG_BLOCK: prdata = 32'(blk_reg);
            sawbc_pkg::REG_SETS:  prdata = 32'(sets_reg);
            default:              prdata = 32'd0;
        endcase
    end

    assign geo = sawbc_pkg::geo_settle(ways_reg, blk_reg, sets_reg);

    sawbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .geo      (geo),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .div_done (div_done),
        .cmd      (cmd)
    );

    sawbc_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .geo           (geo),
        .cmd           (cmd),
        .in_op         (s_tdata[0]),
        .in_address    (s_tdata[16:1]),
        .in_write_data (s_tdata[24:17]),
        .pct           (pct),
        .sts           (sts),
        .miss_cnt      (miss_cnt),
        .total         (total),
        .read_data     (read_data),
        .hit           (hit),
        .miss_percent  (miss_percent)
    );

    sawbc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == sawbc_pkg::CMD_RESULT),
        .miss_cnt (miss_cnt),
        .total    (total),
        .done     (div_done),
        .quotient (pct)
    );

    assign m_tdata = {miss_percent, hit, read_data};

endmodule

// ----- rtl/core/sawbc_div.sv -----
// Bit-serial divider for the miss percentage, one quotient bit a cycle.
// Depends on sawbc_pkg.
`timescale 1ns / 1ps

module sawbc_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [sawbc_pkg::CNT_BITS-1:0]     miss_cnt,
    input  logic [sawbc_pkg::CNT_BITS:0]       total,
    output logic                               done,
    output logic [sawbc_pkg::PCT_BITS-1:0]     quotient
);

    localparam int REM_BITS = sawbc_pkg::CNT_BITS + sawbc_pkg::PCT_BITS;

    logic [REM_BITS-1:0]              rem_reg;
    logic [sawbc_pkg::CNT_BITS:0]     dvs_reg;
    logic [sawbc_pkg::PCT_BITS-1:0]   q_reg;
    logic [2:0]                       step_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic [REM_BITS:0]                shifted;

    assign shifted  = (REM_BITS + 1)'(dvs_reg) << step_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

    // restoring division from the top quotient bit down
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= REM_BITS'(miss_cnt) * REM_BITS'(sawbc_pkg::PCT_SCALE);
                dvs_reg  <= total;
                q_reg    <= '0;
                step_reg <= 3'(sawbc_pkg::PCT_BITS - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if ({1'b0, rem_reg} >= shifted) begin
                    rem_reg        <= REM_BITS'({1'b0, rem_reg} - shifted);
                    q_reg[step_reg] <= 1'b1;
                end
                if (step_reg == 3'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - 3'd1;
                end
            end
        end
    end

endmodule

// ----- rtl/core/sawbc_dpath.sv -----
// Datapath: backing memory, line data, tag store, counters and output register.
// Depends on sawbc_pkg; driven by commands from sawbc_ctrl.
`timescale 1ns / 1ps

module sawbc_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sawbc_pkg::geo_t                     geo,
    input  sawbc_pkg::cmd_t                     cmd,
    input  logic                                in_op,
    input  logic [sawbc_pkg::ADDR_BITS-1:0]     in_address,
    input  logic [7:0]                          in_write_data,
    input  logic [sawbc_pkg::PCT_BITS-1:0]      pct,
    output sawbc_pkg::sts_t                     sts,
    output logic [sawbc_pkg::CNT_BITS-1:0]      miss_cnt,
    output logic [sawbc_pkg::CNT_BITS:0]        total,
    output logic [7:0]                          read_data,
    output logic                                hit,
    output logic [sawbc_pkg::PCT_BITS-1:0]      miss_percent
);

    localparam int AB = sawbc_pkg::ADDR_BITS;
    localparam int SB = sawbc_pkg::SLOT_BITS;
    localparam int LB = sawbc_pkg::LINE_BITS;
    localparam int WB = sawbc_pkg::WAY_BITS;
    localparam int OB = sawbc_pkg::OFF_BITS;
    localparam int CB = sawbc_pkg::CNT_BITS;

    // memories
    logic [7:0]        mem_ram  [sawbc_pkg::MEM_BYTES];
    logic [7:0]        line_ram [sawbc_pkg::CACHE_BYTES];
    sawbc_pkg::meta_t  meta_ram [sawbc_pkg::SLOTS];
    logic [7:0]        mem_q_reg;
    logic [7:0]        line_q_reg;
    sawbc_pkg::meta_t  meta_q_reg;

    // request and address split
    logic          op_reg;
    logic [AB-1:0] addr_reg;
    logic [7:0]    wdata_reg;
    logic [OB-1:0] off_reg;
    logic [SB-1:0] set_reg;
    logic [SB-1:0] slot_base_reg;
    logic [15:0]   tag_reg;

    // way search results
    logic          hit_found_reg;
    logic [WB-1:0] hit_way_reg;
    logic          inv_found_reg;
    logic [WB-1:0] inv_way_reg;
    logic [WB-1:0] best_way_reg;
    logic [CB-1:0] best_age_reg;
    logic [15:0]   best_tag_reg;
    logic          best_dirty_reg;

    // chosen line
    logic [WB-1:0] used_way_reg;
    logic [LB-1:0] dbase_reg;
    logic [AB-1:0] wb_base_reg;
    logic [AB-1:0] fill_base_reg;

    // delayed write of block copies
    logic          copy_pend_reg;
    logic          copy_to_mem_reg;
    logic [OB-1:0] copy_off_reg;

    logic [CB-1:0] hit_cnt_reg;
    logic [CB-1:0] miss_cnt_reg;
    logic [7:0]    rdata_reg;
    logic [7:0]    out_rdata_reg;
    logic          out_hit_reg;
    logic [sawbc_pkg::PCT_BITS-1:0] out_pct_reg;

    logic [OB-1:0]    block_mask;
    logic [SB-1:0]    set_c;
    logic [15:0]      tag_c;
    logic [WB-1:0]    way;
    logic [WB-1:0]    used_way_c;
    logic [SB-1:0]    slot_c;
    logic [SB-1:0]    meta_addr;
    logic             tag_match;
    sawbc_pkg::meta_t meta_new;

    logic          mem_we;
    logic [AB-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AB-1:0] mem_raddr;
    logic          line_we;
    logic [LB-1:0] line_waddr;
    logic [7:0]    line_wdata;
    logic [LB-1:0] line_raddr;
    logic          meta_we;
    logic [SB-1:0] meta_waddr;
    sawbc_pkg::meta_t meta_wdata;

    // address split for the configured geometry
    assign block_mask = OB'((8'd1 << geo.blk) - 8'd1);
    assign set_c      = SB'((addr_reg >> geo.blk) & ((16'd1 << geo.sets) - 16'd1));
    assign tag_c      = 16'(addr_reg >> (5'(geo.blk) + 5'(geo.sets)));
    assign way        = cmd.idx[WB-1:0];
    assign used_way_c = hit_found_reg ? hit_way_reg :
                        (inv_found_reg ? inv_way_reg : best_way_reg);
    assign slot_c     = slot_base_reg + SB'(used_way_c);
    assign meta_addr  = slot_base_reg + SB'(way);
    assign tag_match  = meta_q_reg.valid && (meta_q_reg.tag == tag_reg);

    // age update for the ways of the set
    always_comb begin
        meta_new = meta_q_reg;
        if (way == used_way_reg) begin
            meta_new.valid = 1'b1;
            meta_new.dirty = hit_found_reg ? (meta_q_reg.dirty | op_reg) : op_reg;
            meta_new.tag   = tag_reg;
            meta_new.age   = '0;
        end else if (meta_q_reg.age != '1) begin
            meta_new.age = meta_q_reg.age + CB'(1);
        end
    end

    // memory port selection
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = wb_base_reg + AB'(copy_off_reg);
        mem_wdata  = line_q_reg;
        mem_raddr  = fill_base_reg + AB'(cmd.idx[OB-1:0]);
        line_we    = 1'b0;
        line_waddr = dbase_reg + LB'(copy_off_reg);
        line_wdata = mem_q_reg;
        line_raddr = dbase_reg + LB'(cmd.idx[OB-1:0]);
        meta_we    = 1'b0;
        meta_waddr = meta_addr;
        meta_wdata = meta_new;
        if (cmd.op == sawbc_pkg::CMD_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = cmd.idx;
            mem_wdata = 8'd0;
            if (cmd.idx[AB-1:SB] == '0) begin
                meta_we    = 1'b1;
                meta_waddr = cmd.idx[SB-1:0];
                meta_wdata = '0;
            end
        end
        if (copy_pend_reg && copy_to_mem_reg) begin
            mem_we = 1'b1;
        end
        if (copy_pend_reg && !copy_to_mem_reg) begin
            line_we = 1'b1;
        end
        if (cmd.op == sawbc_pkg::CMD_ACCESS) begin
            line_raddr = dbase_reg + LB'(off_reg);
            if (op_reg) begin
                line_we    = 1'b1;
                line_waddr = dbase_reg + LB'(off_reg);
                line_wdata = wdata_reg;
            end
        end
        if (cmd.op == sawbc_pkg::CMD_TCH_WR) begin
            meta_we = 1'b1;
        end
    end

    // backing memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_ram[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem_ram[mem_raddr];
    end

    // line data store
    always_ff @(posedge aclk) begin
        if (line_we) begin
            line_ram[line_waddr] <= line_wdata;
        end
        line_q_reg <= line_ram[line_raddr];
    end

    // tag, state and age store
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_ram[meta_waddr] <= meta_wdata;
        end
        meta_q_reg <= meta_ram[meta_addr];
    end

    // control state of the datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            copy_pend_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
        end else begin
            copy_pend_reg <= (cmd.op == sawbc_pkg::CMD_WB) || (cmd.op == sawbc_pkg::CMD_FILL);
            if (cmd.op == sawbc_pkg::CMD_ACCESS) begin
                if (hit_found_reg) begin
                    if (hit_cnt_reg != '1) hit_cnt_reg <= hit_cnt_reg + CB'(1);
                end else begin
                    if (miss_cnt_reg != '1) miss_cnt_reg <= miss_cnt_reg + CB'(1);
                end
            end
        end
    end

    // payload registers stepped by command
    always_ff @(posedge aclk) begin
        copy_to_mem_reg <= (cmd.op == sawbc_pkg::CMD_WB);
        copy_off_reg    <= cmd.idx[OB-1:0];
        case (cmd.op)
            sawbc_pkg::CMD_LATCH: begin
                op_reg    <= in_op;
                addr_reg  <= in_address;
                wdata_reg <= in_write_data;
            end
            sawbc_pkg::CMD_SETUP: begin
                off_reg        <= addr_reg[OB-1:0] & block_mask;
                set_reg        <= set_c;
                tag_reg        <= tag_c;
                slot_base_reg  <= SB'(set_c * geo.ways);
                fill_base_reg  <= addr_reg & ~AB'(block_mask);
                hit_found_reg  <= 1'b0;
                inv_found_reg  <= 1'b0;
                best_dirty_reg <= 1'b0;
                best_age_reg   <= '0;
                best_way_reg   <= '0;
            end
            sawbc_pkg::CMD_SCAN_CHK: begin
                if (tag_match && !hit_found_reg) begin
                    hit_found_reg <= 1'b1;
                    hit_way_reg   <= way;
                end
                if (!meta_q_reg.valid && !inv_found_reg) begin
                    inv_found_reg <= 1'b1;
                    inv_way_reg   <= way;
                end
                if (meta_q_reg.valid && (way == '0 || meta_q_reg.age > best_age_reg)) begin
                    best_way_reg   <= way;
                    best_age_reg   <= meta_q_reg.age;
                    best_tag_reg   <= meta_q_reg.tag;
                    best_dirty_reg <= meta_q_reg.dirty;
                end
            end
            sawbc_pkg::CMD_DECIDE: begin
                used_way_reg <= used_way_c;
                dbase_reg    <= LB'(17'(slot_c) << geo.blk);
                wb_base_reg  <= AB'(((32'(best_tag_reg) << geo.sets) | 32'(set_reg)) << geo.blk);
            end
            sawbc_pkg::CMD_RESULT: begin
                rdata_reg <= op_reg ? 8'd0 : line_q_reg;
            end
            sawbc_pkg::CMD_LOAD_OUT: begin
                out_rdata_reg <= rdata_reg;
                out_hit_reg   <= hit_found_reg;
                out_pct_reg   <= pct;
            end
            default: begin
            end
        endcase
    end

    assign sts.hit       = hit_found_reg;
    assign sts.victim_wb = !hit_found_reg && !inv_found_reg && best_dirty_reg;
    assign miss_cnt      = miss_cnt_reg;
    assign total         = (CB + 1)'(hit_cnt_reg) + (CB + 1)'(miss_cnt_reg);
    assign read_data     = out_rdata_reg;
    assign hit           = out_hit_reg;
    assign miss_percent  = out_pct_reg;

endmodule

// ----- rtl/core/sawbc_ctrl.sv -----
// Controller: sequences clearing, way search, write-back, fill, aging and result.
// Depends on sawbc_pkg; drives sawbc_dpath through command and status structs.
`timescale 1ns / 1ps

module sawbc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  sawbc_pkg::geo_t     geo,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  sawbc_pkg::sts_t     sts,
    input  logic                div_done,
    output sawbc_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DECIDE,
        ST_WB,
        ST_FILL,
        ST_TCH_RD,
        ST_TCH_WR,
        ST_ACCESS,
        ST_RESULT,
        ST_DIV,
        ST_DONE
    } state_t;

    localparam int AB = sawbc_pkg::ADDR_BITS;
    localparam int WB = sawbc_pkg::WAY_BITS;
    localparam int OB = sawbc_pkg::OFF_BITS;

    state_t        state_reg, state_next;
    logic [AB-1:0] cnt_reg, cnt_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [WB-1:0] ways_last;
    logic [OB-1:0] block_last;
    logic          out_free;

    assign ways_last  = WB'(geo.ways - 4'd1);
    assign block_last = OB'((8'd1 << geo.blk) - 8'd1);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;

    // next state and command decode
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.op        = sawbc_pkg::CMD_NONE;
        cmd.idx       = cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.op   = sawbc_pkg::CMD_CLEAR;
                cnt_next = cnt_reg + AB'(1);
                if (cnt_reg == '1) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = sawbc_pkg::CMD_LATCH;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.op     = sawbc_pkg::CMD_SETUP;
                cnt_next   = '0;
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                cmd.op     = sawbc_pkg::CMD_SCAN_RD;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                cmd.op = sawbc_pkg::CMD_SCAN_CHK;
                if (cnt_reg[WB-1:0] == ways_last) begin
                    state_next = ST_DECIDE;
                end else begin
                    cnt_next   = cnt_reg + AB'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_DECIDE: begin
                cmd.op   = sawbc_pkg::CMD_DECIDE;
                cnt_next = '0;
                if (sts.hit)            state_next = ST_TCH_RD;
                else if (sts.victim_wb) state_next = ST_WB;
                else                    state_next = ST_FILL;
            end
            ST_WB: begin
                cmd.op   = sawbc_pkg::CMD_WB;
                cnt_next = cnt_reg + AB'(1);
                if (cnt_reg[OB-1:0] == block_last) begin
                    cnt_next   = '0;
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.op   = sawbc_pkg::CMD_FILL;
                cnt_next = cnt_reg + AB'(1);
                if (cnt_reg[OB-1:0] == block_last) begin
                    cnt_next   = '0;
                    state_next = ST_TCH_RD;
                end
            end
            ST_TCH_RD: begin
                cmd.op     = sawbc_pkg::CMD_TCH_RD;
                state_next = ST_TCH_WR;
            end
            ST_TCH_WR: begin
                cmd.op = sawbc_pkg::CMD_TCH_WR;
                if (cnt_reg[WB-1:0] == ways_last) begin
                    state_next = ST_ACCESS;
                end else begin
                    cnt_next   = cnt_reg + AB'(1);
                    state_next = ST_TCH_RD;
                end
            end
            ST_ACCESS: begin
                cmd.op     = sawbc_pkg::CMD_ACCESS;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                cmd.op     = sawbc_pkg::CMD_RESULT;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.op        = sawbc_pkg::CMD_LOAD_OUT;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // an accepted request always goes to address setup
    a_accept_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_SETUP))
        else $error("accepted request did not enter setup");

    // the divider only finishes while the controller waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide wait");

    // a hit skips write-back and fill
    a_hit_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE && sts.hit) |=> (state_reg == ST_TCH_RD))
        else $error("hit did not go straight to aging");

    // a new result is loaded only when the output register is free
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == sawbc_pkg::CMD_LOAD_OUT) |-> out_free)
        else $error("result loaded over a pending one");

endmodule
